### src/urh_pkg.sv
// Shared types and constants for the undo/redo view history ring.
// No dependencies; used by every module of the block.
package urh_pkg;

  localparam int PORT_W  = 8;
  localparam int COORD_W = 17;
  localparam int ACT_W   = 3;

  localparam logic [COORD_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [COORD_W-1:0] ZERO_Q16 = 17'h00000;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNDO   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REDO   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MODE   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] upper_y;
    logic [COORD_W-1:0] right_x;
    logic [COORD_W-1:0] lower_y;
    logic [COORD_W-1:0] left_x;
    logic [PORT_W-1:0]  view_port;
  } entry_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             degenerate;
    logic             crop_mode;
    entry_t           entry;
  } cmd_t;

  function automatic logic is_full_view(input entry_t e);
    return (e.left_x == ZERO_Q16) && (e.lower_y == ZERO_Q16) &&
           (e.right_x == ONE_Q16) && (e.upper_y == ONE_Q16);
  endfunction

endpackage

### src/urh_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on urh_pkg.
module urh_front import urh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  logic             in_crop_mode,
  input  entry_t           in_entry,
  output logic             cmd_valid,
  input  logic             cmd_pop,
  output cmd_t             cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push_in;

  always_comb begin
    cls.crop_mode  = in_crop_mode;
    cls.entry      = in_entry;
    cls.degenerate = (in_entry.left_x == in_entry.right_x) ||
                     (in_entry.lower_y == in_entry.upper_y);
    if ((in_action == ACT_PUSH) || (in_action == ACT_UNDO) || (in_action == ACT_REDO) ||
        (in_action == ACT_PEEK) || (in_action == ACT_UPDATE) || (in_action == ACT_MODE)) begin
      cls.action = in_action;
    end else begin
      cls.action = ACT_NONE;
    end
  end

  assign in_ready  = (count != 2'd2);
  assign push_in   = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_in) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_in) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push_in) - 2'(cmd_pop);
    end
  end

endmodule

### src/urh_back.sv
// Back end: ring indices, history memory and result register.
// Depends on urh_pkg; takes commands from urh_front.
module urh_back import urh_pkg::*; #(
  parameter int LAST_SLOT = 15
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  output logic   cmd_pop,
  input  cmd_t   cmd_in,
  output logic   res_valid,
  input  logic   res_ready,
  output logic   res_done,
  output logic   res_full_view,
  output entry_t res_entry
);

  localparam int SLOTS  = LAST_SLOT + 1;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int ADDR_W = $clog2(2 * SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_SLOT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_PUSH2 = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  entry_t           mem [2*SLOTS];
  entry_t           rd_data;
  logic [1:0]       state, state_next;
  cmd_t             cmd;
  logic [IDX_W-1:0] oldest [2];
  logic [IDX_W-1:0] cursor [2];
  logic [IDX_W-1:0] redo [2];
  logic [IDX_W-1:0] oldest_next [2];
  logic [IDX_W-1:0] cursor_next [2];
  logic [IDX_W-1:0] redo_next [2];
  logic             active, active_next;

  logic [IDX_W-1:0] cur, old, lim, cur_nx, cur_pv, old_nx;
  logic             empty;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  entry_t           wr_data;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic             load;
  logic             load_done, load_fv;
  entry_t           load_entry;
  entry_t           fv_entry;

  assign cur    = cursor[active];
  assign old    = oldest[active];
  assign lim    = redo[active];
  assign cur_nx = (cur == LAST_IDX) ? '0 : cur + 1'b1;
  assign cur_pv = (cur == '0) ? LAST_IDX : cur - 1'b1;
  assign old_nx = (old == LAST_IDX) ? '0 : old + 1'b1;
  assign empty  = (cur == old);

  always_comb begin
    fv_entry           = '0;
    fv_entry.view_port = cmd.entry.view_port;
    fv_entry.right_x   = ONE_Q16;
    fv_entry.upper_y   = ONE_Q16;
  end

  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    cursor_next = cursor;
    redo_next   = redo;
    active_next = active;
    cmd_pop     = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = cur_nx;
    wr_data     = cmd.entry;
    rd_idx      = cur;
    load        = 1'b0;
    load_done   = 1'b0;
    load_fv     = 1'b0;
    load_entry  = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_pop    = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        state_next = ST_IDLE;
        load       = 1'b1;
        unique case (cmd.action)
          ACT_PUSH: begin
            if (!cmd.degenerate) begin
              cursor_next[active] = cur_nx;
              redo_next[active]   = cur_nx;
              if (cur_nx == old) begin
                oldest_next[active] = old_nx;
              end
              wr_en = 1'b1;
              if (empty) begin
                wr_data    = fv_entry;
                load       = 1'b0;
                state_next = ST_PUSH2;
              end else begin
                load_done = 1'b1;
              end
            end
          end
          ACT_UNDO: begin
            if (!empty && (cur_pv != old)) begin
              cursor_next[active] = cur_pv;
              rd_idx              = cur_pv;
              load                = 1'b0;
              state_next          = ST_READ;
            end
          end
          ACT_REDO: begin
            if ((lim != cur) && (cur_nx != old)) begin
              cursor_next[active] = cur_nx;
              rd_idx              = cur_nx;
              load                = 1'b0;
              state_next          = ST_READ;
            end
          end
          ACT_PEEK: begin
            if (empty) begin
              load_done          = 1'b1;
              load_fv            = 1'b1;
              load_entry.right_x = ONE_Q16;
              load_entry.upper_y = ONE_Q16;
            end else begin
              load       = 1'b0;
              state_next = ST_READ;
            end
          end
          ACT_UPDATE: begin
            if (!empty) begin
              wr_en     = 1'b1;
              wr_idx    = cur;
              load_done = 1'b1;
            end
          end
          ACT_MODE: begin
            active_next = cmd.crop_mode;
            if (cmd.crop_mode) begin
              oldest_next[1] = '0;
              cursor_next[1] = '0;
              redo_next[1]   = '0;
            end
            load_done = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_PUSH2: begin
        cursor_next[active] = cur_nx;
        redo_next[active]   = cur_nx;
        if (cur_nx == old) begin
          oldest_next[active] = old_nx;
        end
        wr_en      = 1'b1;
        load       = 1'b1;
        load_done  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        load       = 1'b1;
        load_done  = 1'b1;
        load_fv    = is_full_view(rd_data);
        load_entry = rd_data;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wr_addr = active ? ADDR_W'(wr_idx) + ADDR_W'(SLOTS) : ADDR_W'(wr_idx);
  assign rd_addr = active ? ADDR_W'(rd_idx) + ADDR_W'(SLOTS) : ADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= cmd_in;
    end
    if (load) begin
      res_done      <= load_done;
      res_full_view <= load_fv;
      res_entry     <= load_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        oldest[i] <= '0;
        cursor[i] <= '0;
        redo[i]   <= '0;
      end
    end else begin
      state  <= state_next;
      active <= active_next;
      oldest <= oldest_next;
      cursor <= cursor_next;
      redo   <= redo_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### src/undo_redo_history_ring.sv
// Undo/redo history of view rectangles with an uncropped and a cropped ring of
// LAST_SLOT+1 slots each (one head slot unused). Requests queue in a two-deep
// buffer, so the input side stays ready while the history unit works, until
// both buffer entries are filled. The unit takes one request at a time once the
// previous result has left: fetch (ST_IDLE), execute (ST_RUN), then ST_PUSH2
// for a push onto an empty ring (full view then entry, two writes through the
// single memory write port) or ST_READ for a permitted undo or redo and for a
// peek at a non-empty ring (registered memory read). No clearing pass after reset.
// Depends on urh_pkg, urh_front and urh_back.
module undo_redo_history_ring import urh_pkg::*; #(
  parameter int LAST_SLOT = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // crop_mode, view_port, left_x, lower_y, right_x, upper_y, pad
  input  logic [2:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // out_port, out_left_x, out_lower_y, out_right_x, out_upper_y, pad
  output logic [1:0]  m_tuser   // done_res, full_view
);

  entry_t in_entry;
  cmd_t   cmd;
  logic   cmd_valid;
  logic   cmd_pop;
  logic   res_done;
  logic   res_fv;
  entry_t res_entry;

  always_comb begin
    in_entry.view_port = s_tdata[8:1];
    in_entry.left_x    = s_tdata[25:9];
    in_entry.lower_y   = s_tdata[42:26];
    in_entry.right_x   = s_tdata[59:43];
    in_entry.upper_y   = s_tdata[76:60];
  end

  urh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tuser),
    .in_crop_mode (s_tdata[0]),
    .in_entry     (in_entry),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd)
  );

  urh_back #(
    .LAST_SLOT (LAST_SLOT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd_in        (cmd),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res_done      (res_done),
    .res_full_view (res_fv),
    .res_entry     (res_entry)
  );

  assign m_tdata = {4'b0000, res_entry.upper_y, res_entry.right_x, res_entry.lower_y,
                    res_entry.left_x, res_entry.view_port};
  assign m_tuser = {res_fv, res_done};

endmodule
